[rtl/fic_pkg.sv]
// Shared constants, types and helpers for the FIFO cache hit counter.
package fic_pkg;

	// Default geometry handed to the top level parameters
	localparam int MAX_ENTRIES_DEF = 1024;
	localparam int KEY_BITS_DEF    = 32;

	// Fixed field widths
	localparam int PAGE_KEY_W = 32;
	localparam int CAP_W      = 11;
	localparam int CNT_W      = 32;

	// Stream data widths, padded to whole bytes
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 72;

	// Capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	// Fan-in of one OR-tree node
	localparam int OR_LEAF = 32;

	// Per-cell controls driven by the sequencer
	typedef struct packed {
		logic cmp_en;
		logic shift_en;
	} cell_ctl_t;

	// Saturating increment of a running total
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

[rtl/fic_cell.sv]
// One cache cell: holds a resident key, shifts it on, and compares against the probe.
module fic_cell
	import fic_pkg::*;
#(
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int FILL_W   = 11,
	parameter int INDEX    = 0
) (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic [KEY_BITS-1:0] prev_key,
	input  logic [KEY_BITS-1:0] probe_key,
	input  logic [FILL_W-1:0]   fill,
	output logic [KEY_BITS-1:0] key_q,
	output logic                match_s1
);

	// Take the neighbour's key on a miss
	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			key_q <= prev_key;
		end
	end

	// Compare only while this cell lies inside the resident range
	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			match_s1 <= (FILL_W'(INDEX) < fill) && (key_q == probe_key);
		end
	end

endmodule

[rtl/fic_or_reduce.sv]
// One registered level of the match OR-tree.
module fic_or_reduce
	import fic_pkg::*;
#(
	parameter int IN_W = 1024,
	parameter int LEAF = OR_LEAF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [IN_W-1:0]                   in_bits,
	output logic [(IN_W + LEAF - 1)/LEAF-1:0] grp_q
);

	localparam int OUT_W = (IN_W + LEAF - 1) / LEAF;

	logic [OUT_W*LEAF-1:0] padded;
	logic [OUT_W-1:0]      grp;

	assign padded = (OUT_W*LEAF)'(in_bits);

	// Fold each group of leaves
	for (genvar g = 0; g < OUT_W; g++) begin : g_grp
		assign grp[g] = |padded[g*LEAF +: LEAF];
	end

	// Hold the folded groups for the next level
	always_ff @(posedge clk) begin
		if (en) begin
			grp_q <= grp;
		end
	end

endmodule

[rtl/fifo_cache_hit_counter_unit.sv]
// Top level of the FIFO-replacement cache hit counter.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    page_key
//  m_*       out  m_tvalid/m_tready    hit, hit_total, access_total
//  cfg_*     in   cfg_wen              capacity
//
// A request passes through a compare across the whole row of cells, two registered
// OR-tree levels over the cell matches, an update step that shifts the row on a miss
// and loads the result register, and an idle state in which the next request is taken.
// Reset clears fill count, totals, capacity (to 1024) and the sequencer; cell keys
// are not cleared, cells beyond the fill count never report a match.
// A result waiting on m_tready holds the update step; a new request is taken as soon
// as the previous result sits in the output register.
module fifo_cache_hit_counter_unit
	import fic_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// page_key[31:0]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// hit[0], hit_total[32:1], access_total[64:33], zero pad[71:65]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic                   cfg_wen,
	input  logic [CAP_W-1:0]       cfg_wdata
);

	localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
	localparam int G1_W   = (MAX_ENTRIES + OR_LEAF - 1) / OR_LEAF;
	localparam int G2_W   = (G1_W + OR_LEAF - 1) / OR_LEAF;

	// Sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CMP  = 3'd1;
	localparam logic [2:0] ST_RED1 = 3'd2;
	localparam logic [2:0] ST_RED2 = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]             state_q;
	logic [KEY_BITS-1:0]    probe_q;
	logic [FILL_W-1:0]      fill_q;
	logic [CAP_W-1:0]       cap_q;
	logic [CNT_W-1:0]       hit_cnt_q;
	logic [CNT_W-1:0]       acc_cnt_q;
	logic                   out_valid_q;
	logic                   out_hit_q;
	logic [CNT_W-1:0]       out_hit_cnt_q;
	logic [CNT_W-1:0]       out_acc_cnt_q;

	logic                   in_fire;
	logic                   finish;
	logic                   hit_any;
	logic                   append;
	logic [CMP_W-1:0]       cap_eff;
	cell_ctl_t              ctl;
	logic [KEY_BITS-1:0]    chain_key [MAX_ENTRIES+1];
	logic [MAX_ENTRIES-1:0] match_s1;
	logic [G1_W-1:0]        g1_q;
	logic [G2_W-1:0]        g2_q;
	logic [CNT_W-1:0]       hit_next;
	logic [CNT_W-1:0]       acc_next;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign finish   = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign hit_any  = |g2_q;

	// Capacity zero counts as one; the fill never passes the row length
	assign cap_eff = (cap_q == '0) ? CMP_W'(1) : CMP_W'(cap_q);
	assign append  = (CMP_W'(fill_q) < cap_eff) && (fill_q != FILL_W'(MAX_ENTRIES));

	assign ctl.cmp_en   = (state_q == ST_CMP);
	assign ctl.shift_en = finish && !hit_any;

	assign hit_next = hit_any ? sat_inc(hit_cnt_q) : hit_cnt_q;
	assign acc_next = sat_inc(acc_cnt_q);

	// Sequence one request through compare, reduce and update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_RED1;
				ST_RED1: state_q <= ST_RED2;
				ST_RED2: state_q <= ST_DONE;
				ST_DONE: if (finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Latch the probe key on request
	always_ff @(posedge clk) begin
		if (in_fire) begin
			probe_q <= KEY_BITS'(s_tdata[PAGE_KEY_W-1:0]);
		end
	end

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wen) begin
			cap_q <= cfg_wdata;
		end
	end

	// Advance fill count and totals on completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			hit_cnt_q <= '0;
			acc_cnt_q <= '0;
		end else if (finish) begin
			hit_cnt_q <= hit_next;
			acc_cnt_q <= acc_next;
			if (!hit_any && append) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (finish) begin
			out_hit_q     <= hit_any;
			out_hit_cnt_q <= hit_next;
			out_acc_cnt_q <= acc_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_acc_cnt_q, out_hit_cnt_q, out_hit_q};

	// Row of cells: newest key enters at cell zero, oldest drops off the resident end
	assign chain_key[0] = probe_q;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		fic_cell #(
			.KEY_BITS (KEY_BITS),
			.FILL_W   (FILL_W),
			.INDEX    (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.prev_key  (chain_key[i]),
			.probe_key (probe_q),
			.fill      (fill_q),
			.key_q     (chain_key[i+1]),
			.match_s1  (match_s1[i])
		);
	end

	// Fold the cell matches over two registered levels
	fic_or_reduce #(
		.IN_W (MAX_ENTRIES),
		.LEAF (OR_LEAF)
	) u_red1 (
		.clk     (clk),
		.en      (state_q == ST_RED1),
		.in_bits (match_s1),
		.grp_q   (g1_q)
	);

	fic_or_reduce #(
		.IN_W (G1_W),
		.LEAF (OR_LEAF)
	) u_red2 (
		.clk     (clk),
		.en      (state_q == ST_RED2),
		.in_bits (g1_q),
		.grp_q   (g2_q)
	);

endmodule
